// ===== hw/rtl/fss_pkg.sv =====
// Shared types and constants of the frame skip scheduler.
package fss_pkg;

    localparam int TIME_W       = 48;
    localparam int RATE_W       = 8;
    localparam int MODE_W       = 4;
    localparam int SKIP_W       = 3;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 3;
    localparam int MAX_SKIP     = 5;
    localparam int RATE_RESET   = 60;
    localparam int USEC_PER_SEC = 1000000;

    // 1e6 = 2^6 * 15625: drop the low bits, then divide by the odd part
    localparam int DIV_SHIFT  = 6;
    localparam int DIV_ODD    = USEC_PER_SEC >> DIV_SHIFT;
    localparam int PROD_W     = TIME_W + RATE_W;
    localparam int DIVIDEND_W = PROD_W - DIV_SHIFT;
    localparam int DIGIT_W    = 4;
    localparam int RADIX      = 1 << DIGIT_W;
    localparam int DIV_STAGES = (DIVIDEND_W + DIGIT_W - 1) / DIGIT_W;
    localparam int WORK_W     = DIV_STAGES * DIGIT_W;
    localparam int REM_W      = $clog2(DIV_ODD);
    localparam int PART_W     = REM_W + DIGIT_W;
    localparam int COUNT_W    = $clog2(((64'd1 << PROD_W) / USEC_PER_SEC) + 1);

    localparam logic signed [MODE_W-1:0] MODE_MAX = MODE_W'(MAX_SKIP);
    localparam logic signed [MODE_W-1:0] MODE_MIN = -MODE_MAX;

    typedef enum logic [ADDR_W-3:0] {
        REG_SKIP_MODE  = 1'b0,
        REG_FRAME_RATE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [MODE_W-1:0] mode;
        logic [RATE_W-1:0]        rate;
        logic                     clear;
    } cfg_t;

    typedef struct packed {
        logic restart;
        logic rebase;
    } item_flags_t;

endpackage

// ===== hw/rtl/fss_req_if.sv =====
// Request channel: refresh update or restart with a microsecond timestamp.
interface fss_req_if import fss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] now_usec;

    modport source (output valid, action, now_usec, input ready);
    modport sink (input valid, action, now_usec, output ready);
endinterface

// ===== hw/rtl/fss_res_if.sv =====
// Result channel: skip decision and skip counter after each request.
interface fss_res_if import fss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              skip_next;
    logic [SKIP_W-1:0] skip_count;

    modport source (output valid, skip_next, skip_count, input ready);
    modport sink (input valid, skip_next, skip_count, output ready);
endinterface

// ===== hw/rtl/fss_cfg.sv =====
// APB register file: skip mode with clamping and clear on change, frame rate.
module fss_cfg import fss_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic signed [MODE_W-1:0] mode_reg;
    logic signed [MODE_W-1:0] mode_next;
    logic [RATE_W-1:0]        rate_reg;
    logic [RATE_W-1:0]        rate_next;
    logic signed [MODE_W-1:0] wr_mode;
    logic signed [MODE_W-1:0] clamped;
    logic                     wr_en;
    logic                     clear;
    reg_idx_t                 idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        wr_mode = pwdata[MODE_W-1:0];
        if (wr_mode < MODE_MIN)
        begin
            clamped = MODE_MIN;
        end
        else if (wr_mode > MODE_MAX)
        begin
            clamped = MODE_MAX;
        end
        else
        begin
            clamped = wr_mode;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        rate_next = rate_reg;
        clear     = 1'b0;
        if (wr_en)
        begin
            case (idx)
                REG_SKIP_MODE:
                begin
                    if (clamped != mode_reg)
                    begin
                        mode_next = clamped;
                        clear     = 1'b1;
                    end
                end
                REG_FRAME_RATE:
                begin
                    rate_next = pwdata[RATE_W-1:0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            rate_reg <= RATE_W'(RATE_RESET);
        end
        else
        begin
            mode_reg <= mode_next;
            rate_reg <= rate_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_SKIP_MODE:  prdata = {{(DATA_W-MODE_W){1'b0}}, mode_reg};
            REG_FRAME_RATE: prdata = {{(DATA_W-RATE_W){1'b0}}, rate_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.mode  = mode_reg;
    assign cfg.rate  = rate_reg;
    assign cfg.clear = clear;

endmodule

// ===== hw/rtl/fss_front.sv =====
// Front end: request register, start time tracking, elapsed time and rate product.
module fss_front import fss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    fss_req_if.sink               req,
    output logic                  feed_valid,
    input  logic                  feed_ready,
    output logic [DIVIDEND_W-1:0] dividend,
    output item_flags_t           feed_flags
);

    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic              s0_valid_reg;
    logic [TIME_W-1:0] elapsed_reg;
    item_flags_t       s0_flags_reg;
    logic              s1_valid_reg;
    logic [PROD_W-1:0] product_reg;
    item_flags_t       s1_flags_reg;

    logic              s0_ready;
    logic              s1_ready;
    logic              accept;
    logic              rebase;

    assign s1_ready  = !s1_valid_reg || feed_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign req.ready = s0_ready;
    assign accept    = req.valid && s0_ready;

    // automatic mode restarts the time base when unset or time did not advance
    assign rebase = !req.action && cfg.mode[MODE_W-1]
                 && ((start_reg == '0) || (req.now_usec <= start_reg));

    always_comb
    begin
        start_next = start_reg;
        if (cfg.clear)
        begin
            start_next = '0;
        end
        else if (accept && req.action)
        begin
            start_next = '0;
        end
        else if (accept && rebase)
        begin
            start_next = req.now_usec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            if (s0_ready)
            begin
                s0_valid_reg <= req.valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elapsed_reg          <= req.now_usec - start_reg;
            s0_flags_reg.restart <= req.action;
            s0_flags_reg.rebase  <= rebase;
        end
        if (s0_valid_reg && s1_ready)
        begin
            product_reg  <= {{RATE_W{1'b0}}, elapsed_reg} * {{TIME_W{1'b0}}, cfg.rate};
            s1_flags_reg <= s0_flags_reg;
        end
    end

    assign feed_valid = s1_valid_reg;
    assign dividend   = product_reg[PROD_W-1:DIV_SHIFT];
    assign feed_flags = s1_flags_reg;

endmodule

// ===== hw/rtl/fss_div.sv =====
// Pipelined divide by the odd part of one million, one radix-16 digit per stage.
module fss_div import fss_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  feed_valid,
    output logic                  feed_ready,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  item_flags_t           feed_flags,
    output logic                  done_valid,
    input  logic                  done_ready,
    output logic [COUNT_W-1:0]    quotient,
    output item_flags_t           done_flags
);

    logic              valid_reg [DIV_STAGES];
    logic [WORK_W-1:0] work_reg  [DIV_STAGES];
    logic [REM_W-1:0]  rem_reg   [DIV_STAGES];
    item_flags_t       flags_reg [DIV_STAGES];

    logic              stage_ready [DIV_STAGES];
    logic              valid_in    [DIV_STAGES];
    logic [WORK_W-1:0] work_in     [DIV_STAGES];
    logic [REM_W-1:0]  rem_in      [DIV_STAGES];
    item_flags_t       flags_in    [DIV_STAGES];
    logic [PART_W-1:0] part        [DIV_STAGES];
    logic [DIGIT_W-1:0] digit      [DIV_STAGES];
    logic [PART_W-1:0] rem_full    [DIV_STAGES];

    always_comb
    begin
        stage_ready[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || done_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        valid_in[0] = feed_valid;
        work_in[0]  = WORK_W'(dividend);
        rem_in[0]   = '0;
        flags_in[0] = feed_flags;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            valid_in[k] = valid_reg[k-1];
            work_in[k]  = work_reg[k-1];
            rem_in[k]   = rem_reg[k-1];
            flags_in[k] = flags_reg[k-1];
        end
    end

    // remainder stays below the divisor, so the partial value is below 16x it
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            part[k]  = {rem_in[k], work_in[k][WORK_W-1 -: DIGIT_W]};
            digit[k] = '0;
            for (int j = 1; j < RADIX; j++)
            begin
                if (part[k] >= PART_W'(j * DIV_ODD))
                begin
                    digit[k] = DIGIT_W'(j);
                end
            end
            rem_full[k] = part[k] - PART_W'(digit[k]) * PART_W'(DIV_ODD);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (stage_ready[k] && valid_in[k])
            begin
                work_reg[k]  <= {work_in[k][WORK_W-DIGIT_W-1:0], digit[k]};
                rem_reg[k]   <= rem_full[k][REM_W-1:0];
                flags_reg[k] <= flags_in[k];
            end
        end
    end

    assign feed_ready = stage_ready[0];
    assign done_valid = valid_reg[DIV_STAGES-1];
    assign quotient   = work_reg[DIV_STAGES-1][COUNT_W-1:0];
    assign done_flags = flags_reg[DIV_STAGES-1];

endmodule

// ===== hw/rtl/fss_back.sv =====
// Back end: virtual frame count, skip counter update and result register.
module fss_back import fss_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               feed_valid,
    output logic               feed_ready,
    input  logic [COUNT_W-1:0] elapsed_frames,
    input  item_flags_t        feed_flags,
    fss_res_if.source          res
);

    logic [TIME_W-1:0] vf_reg;
    logic [TIME_W-1:0] vf_next;
    logic [SKIP_W-1:0] run_reg;
    logic [SKIP_W-1:0] run_next;
    logic              out_valid_reg;
    logic              out_skip_reg;
    logic [SKIP_W-1:0] out_count_reg;

    logic              load;
    logic              mode_pos;
    logic              mode_neg;
    logic [MODE_W-1:0] mode_mag;
    logic [SKIP_W-1:0] limit;
    logic [SKIP_W-1:0] run_inc;
    logic [TIME_W-1:0] vf_inc;
    logic [TIME_W-1:0] rc;

    assign feed_ready = !out_valid_reg || res.ready;
    assign load       = feed_valid && feed_ready;

    assign mode_neg = cfg.mode[MODE_W-1];
    assign mode_pos = !cfg.mode[MODE_W-1] && (cfg.mode != '0);
    assign mode_mag = mode_neg ? -cfg.mode : cfg.mode;
    assign limit    = mode_mag[SKIP_W-1:0];
    assign run_inc  = run_reg + 1'b1;
    assign vf_inc   = vf_reg + 1'b1;
    assign rc       = TIME_W'(elapsed_frames);

    always_comb
    begin
        vf_next  = vf_reg;
        run_next = run_reg;
        if (cfg.clear)
        begin
            vf_next  = '0;
            run_next = '0;
        end
        else if (load)
        begin
            if (feed_flags.restart || feed_flags.rebase)
            begin
                vf_next  = '0;
                run_next = '0;
            end
            else if (mode_pos)
            begin
                run_next = (run_inc > limit) ? '0 : run_inc;
            end
            else if (mode_neg)
            begin
                vf_next = vf_inc;
                if (rc >= vf_inc)
                begin
                    // behind: keep skipping up to the limit, then resync
                    if ((rc > vf_inc) && (run_reg < limit))
                    begin
                        run_next = run_inc;
                    end
                    else
                    begin
                        vf_next  = rc;
                        run_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg        <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vf_reg  <= vf_next;
            run_reg <= run_next;
            if (feed_ready)
            begin
                out_valid_reg <= feed_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_skip_reg  <= (cfg.mode != '0) && (run_next != '0);
            out_count_reg <= run_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.skip_next  = out_skip_reg;
    assign res.skip_count = out_count_reg;

endmodule

// ===== hw/rtl/frame_skip_scheduler_unit.sv =====
// Frame skip scheduler top level: APB registers, request pipeline, result channel.
//
// One request (refresh update with timestamp, or restart) is taken per clock
// when neither side stalls; it passes through two front stages (elapsed time,
// then the elapsed-time by frame-rate product), 13 pipelined radix-16 divider
// stages that turn the product into whole frames (divide by one million), and
// the result register, whose stage also updates the virtual frame count and
// skip counter. Back-pressure on the result side stalls only as far up the
// pipeline as needed, so empty stages keep taking requests. Skip mode 0 is off,
// a positive mode N renders one and skips N, a negative mode catches up
// automatically with at most |N| skips in a row; writes are clamped to the
// supported range and a changed mode clears the state. Write the registers only
// while no request is in flight.
module frame_skip_scheduler_unit import fss_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    fss_req_if.sink           req,
    fss_res_if.source         res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t                  cfg_bus;
    logic                  div_feed_valid;
    logic                  div_feed_ready;
    logic [DIVIDEND_W-1:0] div_dividend;
    item_flags_t           div_feed_flags;
    logic                  back_feed_valid;
    logic                  back_feed_ready;
    logic [COUNT_W-1:0]    elapsed_frames;
    item_flags_t           back_feed_flags;

    fss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg_bus)
    );

    fss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .req        (req),
        .feed_valid (div_feed_valid),
        .feed_ready (div_feed_ready),
        .dividend   (div_dividend),
        .feed_flags (div_feed_flags)
    );

    fss_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (div_feed_valid),
        .feed_ready (div_feed_ready),
        .dividend   (div_dividend),
        .feed_flags (div_feed_flags),
        .done_valid (back_feed_valid),
        .done_ready (back_feed_ready),
        .quotient   (elapsed_frames),
        .done_flags (back_feed_flags)
    );

    fss_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_bus),
        .feed_valid     (back_feed_valid),
        .feed_ready     (back_feed_ready),
        .elapsed_frames (elapsed_frames),
        .feed_flags     (back_feed_flags),
        .res            (res)
    );

`ifndef ASSERT_OFF
    // a skip is only reported with a nonzero counter
    a_skip_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.skip_next |-> res.skip_count != '0)
        else $error("skip reported with zero skip counter");

    // the counter never runs past the largest mode
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.skip_count <= SKIP_W'(MAX_SKIP))
        else $error("skip counter above limit");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the frame skip scheduler: APB setup, request and result channels.
`timescale 1ns / 1ps

module testbench;
    import fss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SHOW_LIMIT  = 10;

    typedef struct {
        logic              action;
        logic [TIME_W-1:0] now_usec;
    } refresh_req_t;

    typedef struct {
        logic              skip_next;
        logic [SKIP_W-1:0] skip_count;
    } skip_decision_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    fss_req_if req_ch ();
    fss_res_if res_ch ();

    frame_skip_scheduler_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    refresh_req_t   refresh_queue[$];
    skip_decision_t expected_decisions[$];

    // scheduler state as predicted from the accepted requests
    int                sched_mode;
    logic [RATE_W-1:0] sched_rate;
    logic [TIME_W-1:0] sched_start;
    logic [TIME_W-1:0] sched_vframes;
    int                sched_skips;

    logic [TIME_W-1:0] time_cursor;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic              hold_arm;
    int                hold_left;
    int                fail_count;
    int                cycle_count;
    int                requests_sent;
    int                restarts_sent;
    int                results_seen;
    int                skips_seen;
    int                reg_writes;

    always #1 clk = ~clk;

    function automatic void clear_schedule();
        sched_start   = '0;
        sched_vframes = '0;
        sched_skips   = 0;
    endfunction

    function automatic void load_mode(logic [MODE_W-1:0] raw);
        int m;
        m = int'($signed(raw));
        if (m < -MAX_SKIP)
            m = -MAX_SKIP;
        if (m > MAX_SKIP)
            m = MAX_SKIP;
        if (m != sched_mode)
        begin
            sched_mode = m;
            clear_schedule();
        end
    endfunction

    function automatic skip_decision_t schedule_step(logic action, logic [TIME_W-1:0] now);
        logic [63:0]    elapsed;
        logic [63:0]    real_frames;
        int             limit;
        skip_decision_t d;
        limit = (sched_mode < 0) ? -sched_mode : sched_mode;
        if (action)
            clear_schedule();
        else if (sched_mode > 0)
        begin
            sched_skips++;
            if (sched_skips > limit)
                sched_skips = 0;
        end
        else if (sched_mode < 0)
        begin
            if (sched_start == '0 || now <= sched_start)
            begin
                // rebase on unset start or time not advancing
                sched_start   = now;
                sched_vframes = '0;
                sched_skips   = 0;
            end
            else
            begin
                elapsed     = {16'd0, now - sched_start};
                real_frames = (elapsed * 64'(sched_rate)) / 64'(USEC_PER_SEC);
                sched_vframes = sched_vframes + 1'b1;
                if (real_frames >= {16'd0, sched_vframes})
                begin
                    if (real_frames > {16'd0, sched_vframes} && sched_skips < limit)
                        sched_skips++;
                    else
                    begin
                        sched_vframes = real_frames[TIME_W-1:0];
                        sched_skips   = 0;
                    end
                end
            end
        end
        d.skip_next  = (sched_mode != 0 && sched_skips > 0);
        d.skip_count = SKIP_W'(sched_skips);
        return d;
    endfunction

    function automatic void flag_failure(string what);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("%s", what);
    endfunction

    // request driver
    always @(posedge clk)
    begin : drv
        refresh_req_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_decisions.push_back(schedule_step(req_ch.action, req_ch.now_usec));
                requests_sent++;
                if (req_ch.action)
                    restarts_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (refresh_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = refresh_queue.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.action   <= nxt.action;
                    req_ch.now_usec <= nxt.now_usec;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : mon
        skip_decision_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (res_ch.skip_next === 1'b1)
                    skips_seen++;
                if (expected_decisions.size() == 0)
                    flag_failure($sformatf("result %0d arrived with no request pending: %0b/%0d",
                                           results_seen, res_ch.skip_next, res_ch.skip_count));
                else
                begin
                    want = expected_decisions.pop_front();
                    if (res_ch.skip_next !== want.skip_next
                        || res_ch.skip_count !== want.skip_count)
                        flag_failure($sformatf(
                            "result %0d: expected skip_next=%0b skip_count=%0d, got %0b/%0d",
                            results_seen, want.skip_next, want.skip_count,
                            res_ch.skip_next, res_ch.skip_count));
                end
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SKIP_MODE)
            load_mode(value[MODE_W-1:0]);
        else
            sched_rate = value[RATE_W-1:0];
        reg_writes++;
    endtask

    task automatic write_mode(int m);
        apb_write(REG_SKIP_MODE, DATA_W'(m[MODE_W-1:0]));
    endtask

    task automatic write_rate(int r);
        apb_write(REG_FRAME_RATE, DATA_W'(r[RATE_W-1:0]));
    endtask

    task automatic queue_item(logic action, logic [TIME_W-1:0] now);
        refresh_req_t it;
        it.action   = action;
        it.now_usec = now;
        refresh_queue.push_back(it);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // wait until every request has gone out and its result came back
    task automatic drain();
        @(negedge clk);
        while (refresh_queue.size() != 0 || req_ch.valid || expected_decisions.size() != 0
               || hold_left != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int mode, int rate, int count, int send_pct, int recv_pct,
                                bit hold_off);
        logic [63:0]       r64;
        logic [TIME_W-1:0] step;
        int                period;
        int                roll;
        int                pick;
        write_mode(mode);
        write_rate(rate);
        set_idling(send_pct, recv_pct);
        if (hold_off)
        begin
            @(posedge clk);
            hold_arm <= 1'b1;
            @(posedge clk);
            hold_arm <= 1'b0;
        end
        period = (rate == 0) ? 16667 : 1000000 / rate;
        r64 = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            time_cursor = r64[TIME_W-1:0];
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            r64  = {$urandom, $urandom};
            if (roll < 4)
                queue_item(1'b1, r64[TIME_W-1:0]);
            else if (roll < 9)
                queue_item(1'b0, r64[TIME_W-1:0]);
            else
            begin
                if (roll < 12)
                    time_cursor = time_cursor - TIME_W'($urandom_range(3 * period));
                else
                begin
                    // mostly on-time refreshes, some late ones to force catch-up
                    pick = $urandom_range(99);
                    if (pick < 65)
                        step = TIME_W'(period - period / 8 + $urandom_range(period / 4));
                    else if (pick < 85)
                        step = TIME_W'(period * $urandom_range(6, 2));
                    else if (pick < 95)
                        step = TIME_W'($urandom_range(period / 2));
                    else
                        step = TIME_W'($urandom);
                    time_cursor = time_cursor + step;
                end
                queue_item(1'b0, time_cursor);
            end
        end
        drain();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.action   = 1'b0;
        req_ch.now_usec = '0;
        res_ch.ready    = 1'b0;
        hold_arm        = 1'b0;
        hold_left       = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        fail_count      = 0;
        requests_sent   = 0;
        restarts_sent   = 0;
        results_seen    = 0;
        skips_seen      = 0;
        reg_writes      = 0;
        time_cursor     = TIME_W'(1000);
        sched_mode      = 0;
        sched_rate      = RATE_W'(RATE_RESET);
        clear_schedule();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // off mode after reset: extremes of the timestamp and a restart
        @(negedge clk);
        queue_item(1'b0, '0);
        queue_item(1'b0, '1);
        queue_item(1'b1, TIME_W'(123));
        drain();

        // fixed skipping with a restart in the middle
        write_mode(2);
        @(negedge clk);
        for (int i = 0; i < 4; i++)
            queue_item(1'b0, TIME_W'(10 + i));
        queue_item(1'b1, TIME_W'(20));
        queue_item(1'b0, TIME_W'(30));
        drain();

        // above range, clamps to the top fixed mode
        write_mode(7);
        @(negedge clk);
        queue_item(1'b0, TIME_W'(40));
        queue_item(1'b0, TIME_W'(50));
        drain();

        // below range, clamps to the deepest catch-up mode
        write_mode(-8);
        @(negedge clk);
        queue_item(1'b0, TIME_W'(1000));
        queue_item(1'b0, TIME_W'(1000));
        queue_item(1'b0, TIME_W'(500));
        queue_item(1'b0, TIME_W'(500 + 16667));
        queue_item(1'b0, TIME_W'(500 + 100000));
        queue_item(1'b0, TIME_W'(500 + 100001));
        queue_item(1'b0, TIME_W'(500 + 100002));
        queue_item(1'b0, '1);
        queue_item(1'b1, '0);
        queue_item(1'b0, '0);
        queue_item(1'b0, TIME_W'(5));
        drain();

        // zero rate never counts real frames
        write_rate(0);
        @(negedge clk);
        queue_item(1'b0, TIME_W'(1000000000));
        queue_item(1'b0, '1);
        drain();

        // same clamped mode again must keep the state
        write_rate(255);
        write_mode(-5);
        @(negedge clk);
        queue_item(1'b0, TIME_W'(3000005));
        drain();

        random_phase(-5,  60, 220,  0,  0, 1'b0);
        random_phase(-5,  50, 220, 77,  0, 1'b0);
        random_phase( 3, 240, 200,  0, 77, 1'b0);
        random_phase(-1,   1, 220, 28, 28, 1'b0);
        random_phase( 0,  60, 150, 28, 28, 1'b0);
        random_phase(-8, 255, 250,  0,  0, 1'b1);
        random_phase( 7,   0, 150, 77,  0, 1'b0);
        random_phase(-2, 144, 180, 28, 28, 1'b0);
        random_phase(-6,   0, 150,  0, 77, 1'b0);

        drain();
        repeat (32) @(posedge clk);
        if (expected_decisions.size() != 0)
            flag_failure($sformatf("%0d results never arrived", expected_decisions.size()));

        $display("checked %0d requests (%0d restarts) across %0d register writes",
                 requests_sent, restarts_sent, reg_writes);
        $display("%0d results compared, %0d of them skip decisions, %0d errors",
                 results_seen, skips_seen, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

endmodule
